### rtl/kea_pkg.sv
// shared types and constants for the keystone edge anti-alias blend
`default_nettype none

package kea_pkg;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SIDE_SELECT = 2'd0,
    REG_EDGE_DELTA  = 2'd1,
    REG_BACKGROUND  = 2'd2
  } cfg_reg_t;

  // where the blended pixel lands, decided in the front
  typedef enum logic [1:0] {
    MODE_LEFT,
    MODE_LEFT_SHIFT,
    MODE_RIGHT,
    MODE_RIGHT_SHIFT
  } slot_mode_t;

  localparam logic [7:0]  ALPHA_OPAQUE = 8'hff;
  localparam logic [7:0]  FRAC_MAX     = 8'hff;
  localparam logic [8:0]  WEIGHT_FULL  = 9'd256;
  localparam logic [16:0] ALPHA_SCALE  = 17'd65536;

  localparam logic [3:0] MASK_LEFT        = 4'h3;
  localparam logic [3:0] MASK_LEFT_SHIFT  = 4'h7;
  localparam logic [3:0] MASK_RIGHT       = 4'h7;
  localparam logic [3:0] MASK_RIGHT_SHIFT = 4'hf;

  typedef struct packed {
    logic               side_select;
    logic signed [31:0] edge_delta;
    logic [23:0]        background_color;
  } cfg_t;

  typedef struct packed {
    logic [31:0] edge_pixel;
    logic [8:0]  weight;
    slot_mode_t  mode;
  } job_t;

endpackage

`default_nettype wire

### rtl/kea_if.sv
// valid/ready channel interfaces for items, results and register writes
`default_nettype none

interface kea_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] edge_pixel;
  logic        first_line;
  modport source (output valid, edge_pixel, first_line, input ready);
  modport sink   (input valid, edge_pixel, first_line, output ready);
endinterface

interface kea_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] slot_outer;
  logic [31:0] slot_second;
  logic [31:0] slot_third;
  logic [31:0] slot_fourth;
  logic [3:0]  write_mask;
  modport source (output valid, slot_outer, slot_second, slot_third, slot_fourth,
                  write_mask, input ready);
  modport sink   (input valid, slot_outer, slot_second, slot_third, slot_fourth,
                  write_mask, output ready);
endinterface

interface kea_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [kea_pkg::CFG_ADDR_W-1:0]  addr;
  logic [kea_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

`default_nettype wire

### rtl/kea_front.sv
// front: position accumulator, weight and slot mode for each accepted line
`default_nettype none

module kea_front #(
  parameter int FRAC_BITS = 18
) (
  input  wire logic          clk,
  input  wire logic          rst,
  kea_in_if.sink             item,
  input  wire kea_pkg::cfg_t cfg,
  input  wire logic          q_full,
  output logic               push,
  output kea_pkg::job_t      job
);

  logic [31:0] acc;
  logic [31:0] acc_next;
  logic [31:0] pos;
  logic [7:0]  frac;
  logic        delta_pos;
  logic        delta_neg;

  assign item.ready = !q_full;
  assign push       = item.valid && !q_full;

  always_comb begin
    // first line of a frame restarts the edge position
    pos       = item.first_line ? '0 : acc;
    frac      = pos[FRAC_BITS-1 -: 8];
    acc_next  = pos + $unsigned(cfg.edge_delta);
    delta_neg = cfg.edge_delta[31];
    delta_pos = !cfg.edge_delta[31] && (|cfg.edge_delta);

    job.edge_pixel = item.edge_pixel;
    if (!cfg.side_select) begin
      job.weight = {1'b0, frac};
      job.mode   = (delta_pos && frac == '0) ? kea_pkg::MODE_LEFT_SHIFT
                                             : kea_pkg::MODE_LEFT;
    end else begin
      job.weight = kea_pkg::WEIGHT_FULL - {1'b0, frac};
      // weight of one on the right side
      job.mode   = (delta_neg && frac == kea_pkg::FRAC_MAX) ? kea_pkg::MODE_RIGHT_SHIFT
                                                           : kea_pkg::MODE_RIGHT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (push) begin
      acc <= acc_next;
    end
  end

endmodule

`default_nettype wire

### rtl/kea_queue.sv
// short job queue between front and back
`default_nettype none

module kea_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire kea_pkg::job_t push_data,
  output logic               full,
  input  wire logic          pop,
  output kea_pkg::job_t      pop_data,
  output logic               empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  kea_pkg::job_t    entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count out of range");

endmodule

`default_nettype wire

### rtl/kea_back.sv
// back: channel and alpha blend, slot placement and output register
`default_nettype none

module kea_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire kea_pkg::job_t job,
  input  wire logic          q_empty,
  output logic               pop,
  input  wire logic [23:0]   background_color,
  kea_out_if.source          result
);

  logic [8:0]  inv_w;
  logic [16:0] mix [3];
  logic [23:0] color;
  logic [7:0]  a_in;
  logic [8:0]  a9;
  logic [8:0]  na;
  logic [16:0] prod;
  logic [16:0] t17;
  logic [8:0]  t;
  logic [8:0]  alpha9;
  logic [31:0] np;
  logic [31:0] opaque_bg;
  logic [31:0] s1_next, s2_next, s3_next;
  logic [3:0]  mask_next;

  logic        out_valid;
  logic [31:0] s0, s1, s2, s3;
  logic [3:0]  mask;

  assign pop = !q_empty && (!out_valid || result.ready);

  always_comb begin
    inv_w = kea_pkg::WEIGHT_FULL - job.weight;
    for (int ch = 0; ch < 3; ch++) begin
      mix[ch] = 17'(job.edge_pixel[8*ch +: 8]) * 17'(inv_w)
              + 17'(background_color[8*ch +: 8]) * 17'(job.weight);
      color[8*ch +: 8] = mix[ch][15:8];
    end
    // coverage of the edge pixel merged with the weight
    a_in   = job.edge_pixel[31:24];
    a9     = {1'b0, a_in} + 9'(a_in != '0);
    na     = kea_pkg::WEIGHT_FULL - a9;
    prod   = 17'(na) * 17'(inv_w);
    t17    = kea_pkg::ALPHA_SCALE - prod;
    t      = t17[16:8];
    alpha9 = t - 9'(t != '0);
    np     = {alpha9[7:0], color};
  end

  always_comb begin
    opaque_bg = {kea_pkg::ALPHA_OPAQUE, background_color};
    s1_next   = '0;
    s2_next   = '0;
    s3_next   = '0;
    mask_next = kea_pkg::MASK_LEFT;
    case (job.mode)
      kea_pkg::MODE_LEFT: begin
        s1_next   = np;
        mask_next = kea_pkg::MASK_LEFT;
      end
      kea_pkg::MODE_LEFT_SHIFT: begin
        s1_next   = opaque_bg;
        s2_next   = np;
        mask_next = kea_pkg::MASK_LEFT_SHIFT;
      end
      kea_pkg::MODE_RIGHT: begin
        s1_next   = opaque_bg;
        s2_next   = np;
        mask_next = kea_pkg::MASK_RIGHT;
      end
      kea_pkg::MODE_RIGHT_SHIFT: begin
        s1_next   = opaque_bg;
        s2_next   = opaque_bg;
        s3_next   = np;
        mask_next = kea_pkg::MASK_RIGHT_SHIFT;
      end
      default: begin
        s1_next   = np;
        mask_next = kea_pkg::MASK_LEFT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s0   <= opaque_bg;
      s1   <= s1_next;
      s2   <= s2_next;
      s3   <= s3_next;
      mask <= mask_next;
    end
  end

  assign result.valid       = out_valid;
  assign result.slot_outer  = s0;
  assign result.slot_second = s1;
  assign result.slot_third  = s2;
  assign result.slot_fourth = s3;
  assign result.write_mask  = mask;

  a_mask_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (mask == kea_pkg::MASK_LEFT || mask == kea_pkg::MASK_LEFT_SHIFT ||
                   mask == kea_pkg::MASK_RIGHT_SHIFT))
    else $error("illegal write mask");
  a_outer_opaque: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (s0[31:24] == kea_pkg::ALPHA_OPAQUE))
    else $error("outer slot not opaque");
  a_fourth_masked: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !mask[3]) |-> (s3 == '0))
    else $error("unwritten fourth slot not zero");

endmodule

`default_nettype wire

### rtl/keystone_edge_antialias_blend_top.sv
// keystone edge anti-alias blend: one line edge in, one four-slot result out
// path: an input transfer writes a queue entry, then the output register raises result valid
// throughput: one line per cycle while the result side is ready; the front accumulator add sets the per-line loop
// a stalled result side backs up through the job queue before input ready drops
// reset (rst, synchronous): clears registers, position, queue and result valid
`default_nettype none

module keystone_edge_antialias_blend_top #(
  parameter int FRAC_BITS   = 18,
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic clk,
  input  wire logic rst,
  kea_in_if.sink    item,
  kea_out_if.source result,
  kea_cfg_if.sink   cfg
);

  kea_pkg::cfg_t cfg_regs;
  kea_pkg::job_t push_job;
  kea_pkg::job_t head_job;
  logic          push;
  logic          pop;
  logic          q_full;
  logic          q_empty;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs <= '0;
    end else if (cfg.valid) begin
      case (cfg.addr)
        kea_pkg::REG_SIDE_SELECT: cfg_regs.side_select      <= cfg.data[0];
        kea_pkg::REG_EDGE_DELTA:  cfg_regs.edge_delta       <= $signed(cfg.data);
        kea_pkg::REG_BACKGROUND:  cfg_regs.background_color <= cfg.data[23:0];
        default: ;
      endcase
    end
  end

  kea_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cfg    (cfg_regs),
    .q_full (q_full),
    .push   (push),
    .job    (push_job)
  );

  kea_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_job),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (head_job),
    .empty     (q_empty)
  );

  kea_back u_back (
    .clk              (clk),
    .rst              (rst),
    .job              (head_job),
    .q_empty          (q_empty),
    .pop              (pop),
    .background_color (cfg_regs.background_color),
    .result           (result)
  );

endmodule

`default_nettype wire

### verif/tb.sv
// self-checking testbench for the keystone edge anti-alias blend top level
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_BITS       = 18;
  localparam int NUM_PHASES      = 12;
  localparam int ITEMS_PER_PHASE = 54;
  localparam int QUIET_LIMIT     = 4000;
  localparam int NUM_DIR         = 38;

  typedef struct packed {
    logic [31:0] outer;
    logic [31:0] second;
    logic [31:0] third;
    logic [31:0] fourth;
    logic [3:0]  mask;
  } edge_res_t;

  typedef enum logic {ROW_LINE, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    kea_pkg::cfg_reg_t target;
    logic [31:0]       value;
    logic              first;
    logic              typed;
    edge_res_t         want;
  } dir_row_t;

  localparam edge_res_t NO_RES = '0;

  // rows with typed results use zero weight or full weight, where the blend is trivial
  localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
    '{ROW_LINE, kea_pkg::REG_SIDE_SELECT, 32'h0000_0000, 1'b1, 1'b1,
      '{32'hff00_0000, 32'h0000_0000, 32'h0, 32'h0, kea_pkg::MASK_LEFT}},
    '{ROW_LINE, kea_pkg::REG_SIDE_SELECT, 32'hffff_ffff, 1'b0, 1'b1,
      '{32'hff00_0000, 32'hffff_ffff, 32'h0, 32'h0, kea_pkg::MASK_LEFT}},
    '{ROW_LINE, kea_pkg::REG_SIDE_SELECT, 32'h80a5_5a01, 1'b0, 1'b1,
      '{32'hff00_0000, 32'h80a5_5a01, 32'h0, 32'h0, kea_pkg::MASK_LEFT}},
    '{ROW_LINE, kea_pkg::REG_SIDE_SELECT, 32'h0100_0000, 1'b0, 1'b1,
      '{32'hff00_0000, 32'h0100_0000, 32'h0, 32'h0, kea_pkg::MASK_LEFT}},
    '{ROW_WRITE, kea_pkg::REG_BACKGROUND, 32'h0012_3456, 1'b0, 1'b0, NO_RES},
    '{ROW_WRITE, kea_pkg::REG_SIDE_SELECT, 32'h0000_0001, 1'b0, 1'b0, NO_RES},
    // right side at full weight: blended pixel is opaque background
    '{ROW_LINE, kea_pkg::REG_SIDE_SELECT, 32'h00ab_cdef, 1'b1, 1'b1,
      '{32'hff12_3456, 32'hff12_3456, 32'hff12_3456, 32'h0, kea_pkg::MASK_RIGHT}},
    '{ROW_LINE, kea_pkg::REG_SIDE_SELECT, 32'hffff_ffff, 1'b0, 1'b1,
      '{32'hff12_3456, 32'hff12_3456, 32'hff12_3456, 32'h0, kea_pkg::MASK_RIGHT}},
    '{ROW_WRITE, kea_pkg::REG_EDGE_DELTA, 32'h7fff_ffff, 1'b0, 1'b0, NO_RES},
    '{ROW_WRITE, kea_pkg::REG_SIDE_SELECT, 32'h0000_0000, 1'b0, 1'b0, NO_RES},
    '{ROW_WRITE, kea_pkg::REG_BACKGROUND, 32'hffff_ffff, 1'b0, 1'b0, NO_RES},
    // positive step with zero weight shifts the pixel inward
    '{ROW_LINE, kea_pkg::REG_SIDE_SELECT, 32'h3c00_ff00, 1'b1, 1'b1,
      '{32'hffff_ffff, 32'hffff_ffff, 32'h3c00_ff00, 32'h0, kea_pkg::MASK_LEFT_SHIFT}},
    '{ROW_LINE, kea_pkg::REG_SIDE_SELECT, 32'h3c00_ff00, 1'b0, 1'b0, NO_RES},
    '{ROW_LINE, kea_pkg::REG_SIDE_SELECT, 32'h00ff_00ff, 1'b0, 1'b0, NO_RES},
    // position wraps past 2^32 here
    '{ROW_LINE, kea_pkg::REG_SIDE_SELECT, 32'hc012_3456, 1'b0, 1'b0, NO_RES},
    '{ROW_WRITE, kea_pkg::REG_EDGE_DELTA, 32'h8000_0000, 1'b0, 1'b0, NO_RES},
    '{ROW_WRITE, kea_pkg::REG_SIDE_SELECT, 32'h0000_0001, 1'b0, 1'b0, NO_RES},
    '{ROW_WRITE, kea_pkg::REG_BACKGROUND, 32'h0000_0000, 1'b0, 1'b0, NO_RES},
    '{ROW_LINE, kea_pkg::REG_SIDE_SELECT, 32'h5a5a_5a5a, 1'b1, 1'b1,
      '{32'hff00_0000, 32'hff00_0000, 32'hff00_0000, 32'h0, kea_pkg::MASK_RIGHT}},
    '{ROW_LINE, kea_pkg::REG_SIDE_SELECT, 32'ha5a5_a5a5, 1'b0, 1'b1,
      '{32'hff00_0000, 32'hff00_0000, 32'hff00_0000, 32'h0, kea_pkg::MASK_RIGHT}},
    // negative step lands on weight one: right side shift
    '{ROW_WRITE, kea_pkg::REG_EDGE_DELTA, 32'hffff_fc00, 1'b0, 1'b0, NO_RES},
    '{ROW_LINE, kea_pkg::REG_SIDE_SELECT, 32'h7f80_4020, 1'b1, 1'b0, NO_RES},
    '{ROW_LINE, kea_pkg::REG_SIDE_SELECT, 32'h7f80_4020, 1'b0, 1'b0, NO_RES},
    '{ROW_LINE, kea_pkg::REG_SIDE_SELECT, 32'hff00_ff00, 1'b0, 1'b0, NO_RES},
    '{ROW_WRITE, kea_pkg::REG_BACKGROUND, 32'h0080_8080, 1'b0, 1'b0, NO_RES},
    '{ROW_WRITE, kea_pkg::REG_EDGE_DELTA, 32'h0004_0000, 1'b0, 1'b0, NO_RES},
    '{ROW_WRITE, kea_pkg::REG_SIDE_SELECT, 32'h0000_0000, 1'b0, 1'b0, NO_RES},
    '{ROW_LINE, kea_pkg::REG_SIDE_SELECT, 32'h1122_3344, 1'b1, 1'b1,
      '{32'hff80_8080, 32'hff80_8080, 32'h1122_3344, 32'h0, kea_pkg::MASK_LEFT_SHIFT}},
    '{ROW_LINE, kea_pkg::REG_SIDE_SELECT, 32'h5566_7788, 1'b0, 1'b1,
      '{32'hff80_8080, 32'hff80_8080, 32'h5566_7788, 32'h0, kea_pkg::MASK_LEFT_SHIFT}},
    '{ROW_WRITE, kea_pkg::REG_EDGE_DELTA, 32'h0002_0000, 1'b0, 1'b0, NO_RES},
    '{ROW_LINE, kea_pkg::REG_SIDE_SELECT, 32'h0000_0000, 1'b1, 1'b1,
      '{32'hff80_8080, 32'hff80_8080, 32'h0000_0000, 32'h0, kea_pkg::MASK_LEFT_SHIFT}},
    '{ROW_LINE, kea_pkg::REG_SIDE_SELECT, 32'hff00_00ff, 1'b0, 1'b0, NO_RES},
    // frame start mid-run clears the position
    '{ROW_LINE, kea_pkg::REG_SIDE_SELECT, 32'h80ff_ffff, 1'b1, 1'b1,
      '{32'hff80_8080, 32'hff80_8080, 32'h80ff_ffff, 32'h0, kea_pkg::MASK_LEFT_SHIFT}},
    '{ROW_WRITE, kea_pkg::REG_EDGE_DELTA, 32'hfffe_0000, 1'b0, 1'b0, NO_RES},
    '{ROW_LINE, kea_pkg::REG_SIDE_SELECT, 32'h1234_5678, 1'b1, 1'b1,
      '{32'hff80_8080, 32'h1234_5678, 32'h0, 32'h0, kea_pkg::MASK_LEFT}},
    '{ROW_LINE, kea_pkg::REG_SIDE_SELECT, 32'h9abc_def0, 1'b0, 1'b0, NO_RES},
    '{ROW_WRITE, kea_pkg::REG_SIDE_SELECT, 32'h0000_0001, 1'b0, 1'b0, NO_RES},
    '{ROW_LINE, kea_pkg::REG_SIDE_SELECT, 32'h9abc_def0, 1'b0, 1'b0, NO_RES}
  };

  logic clk;
  logic rst;

  kea_in_if  in_ch ();
  kea_out_if out_ch ();
  kea_cfg_if cfg_ch ();

  keystone_edge_antialias_blend_top u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (in_ch),
    .result (out_ch),
    .cfg    (cfg_ch)
  );

  // shadow of the block's registers and line position
  logic        sh_side  = 1'b0;
  logic [31:0] sh_delta = '0;
  logic [23:0] sh_bg    = '0;
  logic [31:0] line_pos = '0;

  edge_res_t pending_edges [$];
  int        errors    = 0;
  int        src_idle  = 0;
  int        dst_stall = 0;
  int        quiet     = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [31:0] mix_toward_bg(input logic [31:0] px, input logic [8:0] w);
    int unsigned keep;
    int unsigned a;
    int unsigned t;
    logic [31:0] mixed;
    keep = 256 - w;
    a = px[31:24];
    if (a != 0) a = a + 1;
    t = (65536 - (256 - a) * keep) >> 8;
    if (t != 0) t = t - 1;
    mixed[31:24] = t[7:0];
    for (int i = 0; i < 3; i++)
      mixed[8*i +: 8] = 8'((32'(px[8*i +: 8]) * keep + 32'(sh_bg[8*i +: 8]) * w) >> 8);
    return mixed;
  endfunction

  function automatic edge_res_t predict_edge(input logic [31:0] px, input logic fl);
    edge_res_t   r;
    logic [31:0] opaque;
    logic [31:0] mixed;
    logic [8:0]  w;
    logic        rising;
    logic        falling;
    if (fl) line_pos = '0;
    opaque  = {kea_pkg::ALPHA_OPAQUE, sh_bg};
    rising  = (sh_delta != 0) && !sh_delta[31];
    falling = sh_delta[31];
    r = '0;
    r.outer = opaque;
    if (!sh_side) begin
      w = {1'b0, line_pos[FRAC_BITS-1 -: 8]};
      mixed = mix_toward_bg(px, w);
      if (rising && w == 9'd0) begin
        r.second = opaque;
        r.third  = mixed;
        r.mask   = kea_pkg::MASK_LEFT_SHIFT;
      end else begin
        r.second = mixed;
        r.mask   = kea_pkg::MASK_LEFT;
      end
    end else begin
      w = kea_pkg::WEIGHT_FULL - line_pos[FRAC_BITS-1 -: 8];
      mixed = mix_toward_bg(px, w);
      r.second = opaque;
      if (falling && w == 9'd1) begin
        r.third  = opaque;
        r.fourth = mixed;
        r.mask   = kea_pkg::MASK_RIGHT_SHIFT;
      end else begin
        r.third = mixed;
        r.mask  = kea_pkg::MASK_RIGHT;
      end
    end
    line_pos = line_pos + sh_delta;
    return r;
  endfunction

  // hold off input until every pending result is back, then let the pipe empty
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_edges.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input kea_pkg::cfg_reg_t target, input logic [31:0] value);
    settle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.addr  <= target;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (target)
      kea_pkg::REG_SIDE_SELECT: sh_side  = value[0];
      kea_pkg::REG_EDGE_DELTA:  sh_delta = value;
      kea_pkg::REG_BACKGROUND:  sh_bg    = value[23:0];
      default: ;
    endcase
  endtask

  task automatic push_line(input logic [31:0] px, input logic fl, input logic typed,
                           input edge_res_t want);
    edge_res_t calc;
    while ($urandom_range(99) < src_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.edge_pixel <= px;
    in_ch.first_line <= fl;
    do @(posedge clk); while (!in_ch.ready);
    calc = predict_edge(px, fl);
    pending_edges.push_back(typed ? want : calc);
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= dst_stall);
    end
  end

  always @(posedge clk) begin : check_results
    edge_res_t got;
    edge_res_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = {out_ch.slot_outer, out_ch.slot_second, out_ch.slot_third,
             out_ch.slot_fourth, out_ch.write_mask};
      if (pending_edges.size() == 0) begin
        errors++;
        $display("%0t: result transfer with no line pending: %h %h %h %h mask %h",
                 $time, got.outer, got.second, got.third, got.fourth, got.mask);
      end else begin
        want = pending_edges.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: edge mismatch expected %h %h %h %h mask %h actual %h %h %h %h mask %h",
                   $time, want.outer, want.second, want.third, want.fourth, want.mask,
                   got.outer, got.second, got.third, got.fourth, got.mask);
        end
      end
    end
  end

  // watchdog: cycles in a row with no transfer on any channel
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("FAIL keystone_edge_antialias_blend_top");
      $finish;
    end
  end

  initial begin
    logic [31:0] px;
    logic [31:0] d;
    logic [31:0] v;
    logic        fl;
    int          n;
    int          flen;
    in_ch.valid      <= 1'b0;
    in_ch.edge_pixel <= '0;
    in_ch.first_line <= 1'b0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.addr      <= '0;
    cfg_ch.data      <= '0;
    rst <= 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_DIR; i++) begin
      if (DIR_ROWS[i].kind == ROW_WRITE)
        cfg_write(DIR_ROWS[i].target, DIR_ROWS[i].value);
      else
        push_line(DIR_ROWS[i].value, DIR_ROWS[i].first, DIR_ROWS[i].typed, DIR_ROWS[i].want);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph % 4)
        0: begin src_idle = 0;  dst_stall = 0;  end
        1: begin src_idle = 73; dst_stall = 0;  end
        2: begin src_idle = 0;  dst_stall = 73; end
        default: begin src_idle = 19; dst_stall = 19; end
      endcase

      v = $urandom;
      v[0] = ph[0];
      cfg_write(kea_pkg::REG_SIDE_SELECT, v);
      case ($urandom_range(6))
        0: d = $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
        1: d = $urandom_range(8, 1) << (FRAC_BITS - 8);
        2: d = -($urandom_range(8, 1) << (FRAC_BITS - 8));
        3: d = $urandom;
        4: d = $urandom_range(1 << (FRAC_BITS + 2)) - (1 << (FRAC_BITS + 1));
        5: d = $urandom_range(1) ? ($urandom_range(3, 1) << FRAC_BITS)
                                 : -($urandom_range(3, 1) << FRAC_BITS);
        default: d = '0;
      endcase
      cfg_write(kea_pkg::REG_EDGE_DELTA, d);
      v = $urandom;
      case ($urandom_range(3))
        0: v[23:0] = 24'h00_0000;
        1: v[23:0] = 24'hff_ffff;
        default: ;
      endcase
      cfg_write(kea_pkg::REG_BACKGROUND, v);

      n = 0;
      while (n < ITEMS_PER_PHASE) begin
        // mostly short frames; a few long ones let the position walk far
        flen = ($urandom_range(9) < 8) ? $urandom_range(16, 1) : $urandom_range(60, 17);
        for (int j = 0; j < flen && n < ITEMS_PER_PHASE; j++) begin
          px = $urandom;
          case ($urandom_range(7))
            0: px[31:24] = 8'h00;
            1: px[31:24] = 8'hff;
            2: px = $urandom_range(1) ? 32'h0000_0000 : 32'hffff_ffff;
            default: ;
          endcase
          fl = (j == 0);
          if ($urandom_range(9) == 0) fl = $urandom_range(1);
          push_line(px, fl, 1'b0, NO_RES);
          n++;
          if (n == ITEMS_PER_PHASE / 2 && ph % 3 == 1) settle();
        end
      end
    end

    settle();
    if (errors == 0)
      $display("PASS keystone_edge_antialias_blend_top");
    else
      $display("FAIL keystone_edge_antialias_blend_top");
    $finish;
  end

endmodule
